// ----- rtl/core/pdaw_pkg.sv -----
// ----------------------------------------------------------------------------
// pdaw_pkg
// Shared constants, types and helper functions of the angle-wrapping
// pd controller with time-normalized derivative.
// ----------------------------------------------------------------------------
`default_nettype none

package pdaw_pkg;

   // fixed-point scale points
   localparam int FULL_TURN   = 23040;   // 360 degrees in Q10.6
   localparam int HALF_TURN   = 11520;   // 180 degrees in Q10.6
   localparam int DRIVE_LIMIT = 25600;   // 100.0 in Q8.8

   localparam int GAIN_W    = 16;
   localparam int DRIVE_W   = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;

   typedef logic [CSR_IDX_W-1:0]     csr_idx_type;
   typedef logic signed [GAIN_W-1:0] gain_type;
   typedef logic [14:0]              turn_rem_type;
   typedef logic signed [15:0]       turn_val_type;

   // register map
   localparam csr_idx_type CSR_GAIN_P     = 3'd0;
   localparam csr_idx_type CSR_GAIN_D     = 3'd1;
   localparam csr_idx_type CSR_ENABLE_P   = 3'd2;
   localparam csr_idx_type CSR_ENABLE_D   = 3'd3;
   localparam csr_idx_type CSR_ANGLE_MODE = 3'd4;

   localparam gain_type GAIN_P_RST = 16'sd166;
   localparam gain_type GAIN_D_RST = -16'sd1152;

   // one bit of a serial reduction modulo a full turn, msb first
   function automatic turn_rem_type turn_step(turn_rem_type rem, logic din);
      logic [15:0] r2;
      r2 = {rem, din};
      if (r2 >= 16'(FULL_TURN)) begin
         r2 = r2 - 16'(FULL_TURN);
      end
      return r2[14:0];
   endfunction

   // magnitude remainder plus sign into (-half turn, +half turn]
   function automatic turn_val_type wrap_turn(turn_rem_type rem, logic neg);
      logic [15:0] t;
      t = {1'b0, rem};
      if (neg && (rem != '0)) begin
         t = 16'(FULL_TURN) - {1'b0, rem};
      end
      if (t > 16'(HALF_TURN)) begin
         t = t - 16'(FULL_TURN);
      end
      return turn_val_type'(t);
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/pd_controller_angle_wrap.sv -----
// ----------------------------------------------------------------------------
// pd_controller_angle_wrap
// PD controller with optional angle wrapping and a derivative term that is
// normalized by the elapsed microsecond time between samples.
// ----------------------------------------------------------------------------
// One item is worked on at a time. With EW = max(VALUE_WIDTH+1, 16) and
// QW = EW + 10, each item runs through EW-bit shift-add multipliers and,
// when the derivative is computed, through the restoring divider for dt
// with a QW-bit quotient; the divider is skipped when the derivative is
// zero (first sample or no elapsed time), and angle mode adds the serial
// modulo reduction first. The multipliers take one multiplier bit per
// cycle and the divider produces one quotient bit per cycle. A finished
// result sits in the output register, so the next item can be taken while
// it waits. Configuration writes are always ready and must only be issued
// while the block is idle.
`default_nettype none

module pd_controller_angle_wrap
   import pdaw_pkg::*;
#(
   parameter int VALUE_WIDTH = 16,
   parameter int TIME_WIDTH  = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // input items
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic signed [VALUE_WIDTH-1:0] req_measured,
   input  wire logic signed [VALUE_WIDTH-1:0] req_setpoint,
   input  wire logic [TIME_WIDTH-1:0]         req_time_us,
   // results
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic signed [DRIVE_W-1:0]          rsp_drive,
   // register writes
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire csr_idx_type                   csr_index,
   input  wire logic [CSR_DAT_W-1:0]          csr_wdata
);

   localparam int EW = (VALUE_WIDTH + 1 > 16) ? VALUE_WIDTH + 1 : 16;
   localparam int PW = EW + GAIN_W;
   localparam int QW = PW - 6;
   localparam int SW = QW + 2;
   localparam int CW = $clog2(QW + 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_WRAP = 3'd1;
   localparam logic [2:0] ST_WFIN = 3'd2;
   localparam logic [2:0] ST_MUL  = 3'd3;
   localparam logic [2:0] ST_DIV  = 3'd4;
   localparam logic [2:0] ST_SUM  = 3'd5;

   localparam logic signed [SW-1:0] LIM_HI = SW'(DRIVE_LIMIT);
   localparam logic signed [SW-1:0] LIM_LO = -LIM_HI;

   // control and configuration
   logic [2:0]                    state_ff, state_in;
   logic [CW-1:0]                 cnt_ff, cnt_in;
   gain_type                      gain_p_ff, gain_p_in;
   gain_type                      gain_d_ff, gain_d_in;
   logic                          en_p_ff, en_p_in;
   logic                          en_d_ff, en_d_in;
   logic                          angle_ff, angle_in;
   logic [VALUE_WIDTH-1:0]        last_meas_ff, last_meas_in;
   logic [TIME_WIDTH-1:0]         last_time_ff, last_time_in;
   logic                          time_valid_ff, time_valid_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   // datapath
   logic [EW-1:0]                 errm_ff, errm_in;
   logic [EW-1:0]                 chgm_ff, chgm_in;
   logic                          err_neg_ff, err_neg_in;
   logic                          chg_neg_ff, chg_neg_in;
   turn_rem_type                  rem_e_ff, rem_e_in;
   turn_rem_type                  rem_c_ff, rem_c_in;
   logic [PW-1:0]                 prod_p_ff, prod_p_in;
   logic [PW-1:0]                 prod_d_ff, prod_d_in;
   logic                          neg_p_ff, neg_p_in;
   logic                          neg_d_ff, neg_d_in;
   logic [TIME_WIDTH-1:0]         dt_ff, dt_in;
   logic                          d_zero_ff, d_zero_in;
   logic [QW-1:0]                 quo_ff, quo_in;
   logic [TIME_WIDTH-1:0]         div_rem_ff, div_rem_in;
   logic signed [DRIVE_W-1:0]     drive_ff, drive_in;

   // combinational helpers
   logic                          req_xfer;
   logic signed [EW-1:0]          err_full, chg_full;
   logic signed [EW-1:0]          src_e, src_c;
   logic [EW-1:0]                 abs_e, abs_c;
   logic [GAIN_W-1:0]             mcand_p, mcand_d;
   logic [TIME_WIDTH-1:0]         dt_now;
   logic [GAIN_W:0]               sum_p, sum_d;
   logic [TIME_WIDTH:0]           div_r2;
   logic                          div_ge;
   logic signed [SW-1:0]          p_s, d_s, total;
   logic                          out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_drive = drive_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      err_full = EW'(req_setpoint) - EW'(req_measured);
      chg_full = EW'(req_measured) - EW'($signed(last_meas_ff));
      dt_now   = req_time_us - last_time_ff;

      // operands of the multipliers: raw differences or wrapped ones
      if (state_ff == ST_IDLE) begin
         src_e = err_full;
         src_c = chg_full;
      end else begin
         src_e = EW'(wrap_turn(rem_e_ff, err_neg_ff));
         src_c = EW'(wrap_turn(rem_c_ff, chg_neg_ff));
      end
      abs_e   = src_e[EW-1] ? EW'(-src_e) : EW'(src_e);
      abs_c   = src_c[EW-1] ? EW'(-src_c) : EW'(src_c);
      mcand_p = gain_p_ff[GAIN_W-1] ? GAIN_W'(-gain_p_ff) : GAIN_W'(gain_p_ff);
      mcand_d = gain_d_ff[GAIN_W-1] ? GAIN_W'(-gain_d_ff) : GAIN_W'(gain_d_ff);

      // shift-add step, multiplier bits leave at the bottom
      sum_p = {1'b0, prod_p_ff[PW-1:EW]} + (prod_p_ff[0] ? {1'b0, mcand_p} : '0);
      sum_d = {1'b0, prod_d_ff[PW-1:EW]} + (prod_d_ff[0] ? {1'b0, mcand_d} : '0);

      // restoring divide step
      div_r2 = {div_rem_ff, quo_ff[QW-1]};
      div_ge = (div_r2 >= {1'b0, dt_ff});

      p_s = $signed({2'b00, prod_p_ff[PW-1:6]});
      if (neg_p_ff) begin
         p_s = -p_s;
      end
      d_s = d_zero_ff ? '0 : $signed({2'b00, quo_ff});
      if (neg_d_ff) begin
         d_s = -d_s;
      end
      total = (en_p_ff ? p_s : '0) + (en_d_ff ? d_s : '0);
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      gain_p_in     = gain_p_ff;
      gain_d_in     = gain_d_ff;
      en_p_in       = en_p_ff;
      en_d_in       = en_d_ff;
      angle_in      = angle_ff;
      last_meas_in  = last_meas_ff;
      last_time_in  = last_time_ff;
      time_valid_in = time_valid_ff;
      rsp_valid_in  = rsp_valid_ff;
      errm_in       = errm_ff;
      chgm_in       = chgm_ff;
      err_neg_in    = err_neg_ff;
      chg_neg_in    = chg_neg_ff;
      rem_e_in      = rem_e_ff;
      rem_c_in      = rem_c_ff;
      prod_p_in     = prod_p_ff;
      prod_d_in     = prod_d_ff;
      neg_p_in      = neg_p_ff;
      neg_d_in      = neg_d_ff;
      dt_in         = dt_ff;
      d_zero_in     = d_zero_ff;
      quo_in        = quo_ff;
      div_rem_in    = div_rem_ff;
      drive_in      = drive_ff;

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_GAIN_P:     gain_p_in = gain_type'(csr_wdata);
            CSR_GAIN_D:     gain_d_in = gain_type'(csr_wdata);
            CSR_ENABLE_P:   en_p_in   = csr_wdata[0];
            CSR_ENABLE_D:   en_d_in   = csr_wdata[0];
            CSR_ANGLE_MODE: angle_in  = csr_wdata[0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               last_meas_in  = req_measured;
               last_time_in  = req_time_us;
               time_valid_in = 1'b1;
               dt_in         = dt_now;
               d_zero_in     = !time_valid_ff || (dt_now == '0);
               cnt_in        = '0;
               if (angle_ff) begin
                  errm_in    = abs_e;
                  chgm_in    = abs_c;
                  err_neg_in = err_full[EW-1];
                  chg_neg_in = chg_full[EW-1];
                  rem_e_in   = '0;
                  rem_c_in   = '0;
                  state_in   = ST_WRAP;
               end else begin
                  prod_p_in = {{GAIN_W{1'b0}}, abs_e};
                  prod_d_in = {{GAIN_W{1'b0}}, abs_c};
                  neg_p_in  = gain_p_ff[GAIN_W-1] ^ src_e[EW-1];
                  neg_d_in  = gain_d_ff[GAIN_W-1] ^ src_c[EW-1];
                  state_in  = ST_MUL;
               end
            end
         end
         ST_WRAP: begin
            rem_e_in = turn_step(rem_e_ff, errm_ff[EW-1]);
            rem_c_in = turn_step(rem_c_ff, chgm_ff[EW-1]);
            errm_in  = errm_ff << 1;
            chgm_in  = chgm_ff << 1;
            if (cnt_ff == CW'(EW - 1)) begin
               cnt_in   = '0;
               state_in = ST_WFIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_WFIN: begin
            prod_p_in = {{GAIN_W{1'b0}}, abs_e};
            prod_d_in = {{GAIN_W{1'b0}}, abs_c};
            neg_p_in  = gain_p_ff[GAIN_W-1] ^ src_e[EW-1];
            neg_d_in  = gain_d_ff[GAIN_W-1] ^ src_c[EW-1];
            state_in  = ST_MUL;
         end
         ST_MUL: begin
            prod_p_in = {sum_p, prod_p_ff[EW-1:1]};
            prod_d_in = {sum_d, prod_d_ff[EW-1:1]};
            if (cnt_ff == CW'(EW - 1)) begin
               // numerator of the derivative already scaled by 1/64
               quo_in     = prod_d_in[PW-1:6];
               div_rem_in = '0;
               cnt_in     = '0;
               state_in   = d_zero_ff ? ST_SUM : ST_DIV;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DIV: begin
            div_rem_in = div_ge ? TIME_WIDTH'(div_r2 - {1'b0, dt_ff})
                                : div_r2[TIME_WIDTH-1:0];
            quo_in     = {quo_ff[QW-2:0], div_ge};
            if (cnt_ff == CW'(QW - 1)) begin
               cnt_in   = '0;
               state_in = ST_SUM;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_SUM: begin
            if (out_free) begin
               if (total > LIM_HI) begin
                  drive_in = DRIVE_W'(LIM_HI);
               end else if (total < LIM_LO) begin
                  drive_in = DRIVE_W'(LIM_LO);
               end else begin
                  drive_in = total[DRIVE_W-1:0];
               end
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         gain_p_ff     <= GAIN_P_RST;
         gain_d_ff     <= GAIN_D_RST;
         en_p_ff       <= 1'b1;
         en_d_ff       <= 1'b1;
         angle_ff      <= 1'b0;
         last_meas_ff  <= '0;
         last_time_ff  <= '0;
         time_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         gain_p_ff     <= gain_p_in;
         gain_d_ff     <= gain_d_in;
         en_p_ff       <= en_p_in;
         en_d_ff       <= en_d_in;
         angle_ff      <= angle_in;
         last_meas_ff  <= last_meas_in;
         last_time_ff  <= last_time_in;
         time_valid_ff <= time_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      errm_ff    <= errm_in;
      chgm_ff    <= chgm_in;
      err_neg_ff <= err_neg_in;
      chg_neg_ff <= chg_neg_in;
      rem_e_ff   <= rem_e_in;
      rem_c_ff   <= rem_c_in;
      prod_p_ff  <= prod_p_in;
      prod_d_ff  <= prod_d_in;
      neg_p_ff   <= neg_p_in;
      neg_d_ff   <= neg_d_in;
      dt_ff      <= dt_in;
      d_zero_ff  <= d_zero_in;
      quo_ff     <= quo_in;
      div_rem_ff <= div_rem_in;
      drive_ff   <= drive_in;
   end

   // a new result only comes out of the final summing step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_SUM)
      else $error("result appeared without a completed computation");

   // an accepted item always starts work
   assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> state_ff != ST_IDLE)
      else $error("accepted item did not start");

   // divider partial remainder stays below the nonzero time step
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> (div_rem_ff < dt_ff) && (dt_ff != '0))
      else $error("divider remainder out of range");

   // clamped output never leaves the drive range
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($signed(drive_ff) <= DRIVE_LIMIT)
                       && ($signed(drive_ff) >= -DRIVE_LIMIT))
      else $error("drive outside clamp range");

endmodule

`default_nettype wire
